// ===== rtl/ahlfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ahlfr_pkg: shared types and constants for the length frame receiver
// Byte codes, event codes and the result record passed between stages.
// ----------------------------------------------------------------------------
package ahlfr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned PosW   = 9;
    localparam int unsigned DigitW = 4;

    localparam logic [ByteW-1:0] StxByte   = 8'h02;
    localparam logic [ByteW-1:0] EtxByte   = 8'h03;
    localparam logic [ByteW-1:0] HexLow    = 8'h30;  // '0'
    localparam logic [ByteW-1:0] HexHigh   = 8'h46;  // 'F'
    localparam logic [ByteW-1:0] DigitTop  = 8'h39;  // '9'
    localparam logic [ByteW-1:0] LetterOff = 8'h37;  // '7'

    localparam logic [PosW-1:0] FrameOverhead = 9'd12;
    localparam logic [PosW-1:0] LenHiPos      = 9'd7;
    localparam logic [PosW-1:0] LenLoPos      = 9'd8;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_START   = 3'd1,
        EV_STORED  = 3'd2,
        EV_DONE    = 3'd3,
        EV_ABORT   = 3'd4
    } event_t;

    typedef struct packed {
        event_t          event_res;
        logic [ByteW-1:0] byte_out;
        logic [PosW-1:0]  position;
        logic [PosW-1:0]  frame_length;
    } result_t;

    typedef struct packed {
        logic advance;  // item moves from input register to result register
        logic out_free; // result register empty or being drained
    } flow_t;

endpackage

// ===== rtl/ahlfr_in_reg.sv =====
// ----------------------------------------------------------------------------
// ahlfr_in_reg: input register
// Captures one received byte per request; frees itself when the item advances.
// ----------------------------------------------------------------------------
module ahlfr_in_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ahlfr_pkg::ByteW-1:0]    s_tdata,
    input  ahlfr_pkg::flow_t               flow,
    output logic                           item_valid,
    output logic [ahlfr_pkg::ByteW-1:0]    item_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ahlfr_pkg::ByteW-1:0] byte_reg;

    // room when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || flow.advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ===== rtl/ahlfr_core.sv =====
// ----------------------------------------------------------------------------
// ahlfr_core: frame tracking logic
// Classifies the held byte against the frame state and updates that state.
// ----------------------------------------------------------------------------
module ahlfr_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [ahlfr_pkg::ByteW-1:0] item_byte,
    output ahlfr_pkg::result_t          result
);

    logic                          in_frame_reg;
    logic                          in_frame_next;
    logic [ahlfr_pkg::PosW-1:0]    count_reg;
    logic [ahlfr_pkg::PosW-1:0]    count_next;
    logic [ahlfr_pkg::ByteW-1:0]   plen_reg;
    logic [ahlfr_pkg::ByteW-1:0]   plen_next;
    logic [ahlfr_pkg::DigitW-1:0]  digit_reg;
    logic [ahlfr_pkg::DigitW-1:0]  digit_next;

    logic                          byte_ok;
    logic [ahlfr_pkg::ByteW-1:0]   hex_diff;
    logic [ahlfr_pkg::DigitW-1:0]  hex_val;
    logic [ahlfr_pkg::ByteW-1:0]   plen_tmp;
    logic [ahlfr_pkg::PosW-1:0]    count_inc;
    logic [ahlfr_pkg::PosW-1:0]    limit;

    always_comb
    begin
        byte_ok = ((item_byte >= ahlfr_pkg::HexLow) && (item_byte <= ahlfr_pkg::HexHigh))
                  || (item_byte == ahlfr_pkg::EtxByte);
        hex_diff = (item_byte > ahlfr_pkg::DigitTop) ? (item_byte - ahlfr_pkg::LetterOff)
                                                     : (item_byte - ahlfr_pkg::HexLow);
        hex_val  = hex_diff[ahlfr_pkg::DigitW-1:0];

        digit_next = digit_reg;
        plen_tmp   = plen_reg;
        if (count_reg == ahlfr_pkg::LenHiPos)
        begin
            digit_next = hex_val;
        end
        else if (count_reg == ahlfr_pkg::LenLoPos)
        begin
            plen_tmp = {digit_reg, hex_val};
        end
        count_inc = count_reg + 9'd1;
        limit     = {1'b0, plen_tmp} + ahlfr_pkg::FrameOverhead;

        in_frame_next         = in_frame_reg;
        count_next            = count_reg;
        plen_next             = plen_reg;
        result.event_res      = ahlfr_pkg::EV_IGNORED;
        result.byte_out       = item_byte;
        result.position       = '0;
        result.frame_length   = '0;

        if (item_byte == ahlfr_pkg::StxByte)
        begin
            // start, or restart of a running frame
            digit_next       = digit_reg;
            in_frame_next    = 1'b1;
            count_next       = 9'd1;
            plen_next        = '0;
            result.event_res = ahlfr_pkg::EV_START;
        end
        else if (in_frame_reg)
        begin
            result.position = count_reg;
            if (!byte_ok)
            begin
                digit_next       = digit_reg;
                in_frame_next    = 1'b0;
                count_next       = '0;
                plen_next        = '0;
                result.event_res = ahlfr_pkg::EV_ABORT;
            end
            else if ((count_inc == limit) && (item_byte == ahlfr_pkg::EtxByte))
            begin
                in_frame_next       = 1'b0;
                count_next          = '0;
                plen_next           = '0;
                result.event_res    = ahlfr_pkg::EV_DONE;
                result.frame_length = limit;
            end
            else if (count_inc > limit)
            begin
                // overrun past the announced length
                in_frame_next    = 1'b0;
                count_next       = '0;
                plen_next        = '0;
                result.event_res = ahlfr_pkg::EV_ABORT;
            end
            else
            begin
                count_next       = count_inc;
                plen_next        = plen_tmp;
                result.event_res = ahlfr_pkg::EV_STORED;
            end
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            plen_reg     <= '0;
            digit_reg    <= '0;
        end
        else if (advance)
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            plen_reg     <= plen_next;
            digit_reg    <= digit_next;
        end
    end

endmodule

// ===== rtl/ahlfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// ahlfr_out_reg: result register
// Holds one tagged result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ahlfr_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ahlfr_pkg::result_t result,
    input  logic               m_tready,
    output logic               m_tvalid,
    output ahlfr_pkg::result_t held,
    output ahlfr_pkg::flow_t   flow
);

    logic               valid_reg;
    logic               valid_next;
    ahlfr_pkg::result_t data_reg;

    assign flow.out_free = !valid_reg || m_tready;
    assign flow.advance  = item_valid && flow.out_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (flow.out_free)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = data_reg;

endmodule

// ===== rtl/ascii_hex_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_length_frame_receiver: STX/ETX frame tagger with ASCII-hex length
// Tags each received serial byte with a frame event; no payload buffering.
// ----------------------------------------------------------------------------
// usage
//   slave side: one received byte per request on s_tdata[7:0]
//   master side: one result per byte, event code on m_tuser, byte, position
//   within the frame and completed frame length on m_tdata
//   0x02 opens (or reopens) a frame; positions 7 and 8 carry the two hex
//   digits of the payload length L; a 0x03 landing at count L+12 completes
//   the frame, anything out of range or running past L+12 aborts it
// timing
//   a byte accepted into the input register is classified against the frame
//   state and lands in the result register once that register is free; one
//   byte per cycle sustained while m_tready stays high, through the single classify stage
// reset
//   rst_n clears both stage valids and the frame state (idle, no length)
// stalls
//   while m_tready is low the result register holds, one further byte waits
//   in the input register, then s_tready drops; no byte is lost or repeated
// ----------------------------------------------------------------------------
module ascii_hex_length_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_out, [16:8] position,
                                   // [25:17] frame_length, [31:26] zero
    output logic [2:0]  m_tuser    // [2:0] event_res
);

    ahlfr_pkg::flow_t                flow;
    logic                            item_valid;
    logic [ahlfr_pkg::ByteW-1:0]     item_byte;
    ahlfr_pkg::result_t              result;
    ahlfr_pkg::result_t              held;

    // input register
    ahlfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .flow       (flow),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // frame state and per-byte classification
    ahlfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (flow.advance),
        .item_byte (item_byte),
        .result    (result)
    );

    // result register
    ahlfr_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .held       (held),
        .flow       (flow)
    );

    assign m_tuser = held.event_res;
    assign m_tdata = {6'd0, held.frame_length, held.position, held.byte_out};

`ifndef ASSERT_OFF
    // a completed frame always reports at least the fixed overhead
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ahlfr_pkg::EV_DONE))
        |-> (m_tdata[25:17] >= ahlfr_pkg::FrameOverhead))
        else $error("completed frame shorter than overhead");

    // frame length is only reported with completion
    a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ahlfr_pkg::EV_DONE)) |-> (m_tdata[25:17] == 9'd0))
        else $error("frame length outside completion");

    // start and ignored bytes sit at position zero
    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == ahlfr_pkg::EV_START) || (m_tuser == ahlfr_pkg::EV_IGNORED)))
        |-> (m_tdata[16:8] == 9'd0))
        else $error("nonzero position on start or ignored byte");

    // backpressure only when both stages are occupied and downstream stalls
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (item_valid && m_tvalid && !m_tready))
        else $error("input stalled with free capacity");
`endif

endmodule

// ===== tb/frame_event_checker.sv =====
// ----------------------------------------------------------------------------
// frame_event_checker: result predictor and comparator for the frame receiver
// Follows every byte request on the slave side, works out the frame event it
// should cause and checks it against the result requests on the master side.
// ----------------------------------------------------------------------------
module frame_event_checker
    import ahlfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic [2:0]        m_tuser,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    result_t expected_events[$];

    // mirror of the frame state
    logic             frame_open;
    logic [PosW-1:0]  frame_count;
    logic [ByteW-1:0] length_code;
    logic [3:0]       length_hi;

    function automatic logic [3:0] digit_value(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] v;
        v = (c > DigitTop) ? c - LetterOff : c - HexLow;
        return v[3:0];
    endfunction

    task automatic close_frame();
        frame_open  = 1'b0;
        frame_count = '0;
        length_code = '0;
    endtask

    task automatic classify_byte(input logic [ByteW-1:0] d, output result_t r);
        logic [PosW-1:0] limit;
        logic            legal;
        r.event_res    = EV_IGNORED;
        r.byte_out     = d;
        r.position     = '0;
        r.frame_length = '0;
        if (d == StxByte)
        begin
            frame_open  = 1'b1;
            frame_count = 9'd1;
            length_code = '0;
            r.event_res = EV_START;
        end
        else if (frame_open)
        begin
            legal      = (d >= HexLow && d <= HexHigh) || d == EtxByte;
            r.position = frame_count;
            if (!legal)
            begin
                close_frame();
                r.event_res = EV_ABORT;
            end
            else
            begin
                if (frame_count == LenHiPos)
                    length_hi = digit_value(d);
                else if (frame_count == LenLoPos)
                    length_code = {length_hi, digit_value(d)};
                frame_count = frame_count + 9'd1;
                limit       = {1'b0, length_code} + FrameOverhead;
                if (frame_count == limit && d == EtxByte)
                begin
                    r.event_res    = EV_DONE;
                    r.frame_length = limit;
                    close_frame();
                end
                else if (frame_count > limit)
                begin
                    close_frame();
                    r.event_res = EV_ABORT;
                end
                else
                    r.event_res = EV_STORED;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_result;
        if (!rst_n)
        begin
            close_frame();
            length_hi = '0;
            expected_events.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // results first: one accepted at this edge cannot be from this byte
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 0);
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tuser != want.event_res)
                        report_mismatch("event_res", m_tuser, want.event_res);
                    if (m_tdata[7:0] != want.byte_out)
                        report_mismatch("byte_out", m_tdata[7:0], want.byte_out);
                    if (m_tdata[16:8] != want.position)
                        report_mismatch("position", m_tdata[16:8], want.position);
                    if (m_tdata[25:17] != want.frame_length)
                        report_mismatch("frame_length", m_tdata[25:17],
                                        want.frame_length);
                end
            end
            if (s_tvalid && s_tready)
            begin
                classify_byte(s_tdata, next_result);
                expected_events.push_back(next_result);
            end
            pending <= expected_events.size();
        end
    end

endmodule

// ===== tb/tb_ascii_hex_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_ascii_hex_length_frame_receiver: stimulus and verdict for the receiver
// Feeds directed bytes and then random frames (good, cut short, overrun, with
// noise between them) under random sender gaps and receiver stalls; a
// separate checker predicts each frame event and compares.
// ----------------------------------------------------------------------------
module tb_ascii_hex_length_frame_receiver;
    import ahlfr_pkg::*;

    localparam int unsigned RandomBytes = 1250;
    localparam int unsigned QuietFrom   = 1100;  // no idling past this many bytes
    localparam int unsigned StallLimit  = 2000;  // cycles with no request at all

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;           // [7:0] byte_out, [16:8] position,
                                    // [25:17] frame_length, [31:26] zero
    logic [2:0]  m_tuser;           // [2:0] event_res

    int unsigned fail_count;
    int unsigned pending;
    int unsigned idle_cycles = 0;

    // idling odds in percent, changed per frame; zero means a clean stretch
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ascii_hex_length_frame_receiver i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    frame_event_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog: a run with no request on either side for too long is hung
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: random stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // one byte request, preceded now and then by a gap; returns at the
    // edge where it was taken, with tvalid still high
    task automatic send_byte(input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // body byte of a frame: mostly '0'..'F', now and then a stray end marker
    function automatic logic [7:0] frame_char();
        if ($urandom_range(0, 15) == 0)
            return EtxByte;
        return 8'($urandom_range(HexLow, HexHigh));
    endfunction

    // length digit for a 4-bit value; values 3..9 sometimes use the odd
    // characters ':'..'@' (or the end marker for 3) that decode the same way
    function automatic logic [7:0] digit_char(input logic [3:0] v);
        if (v >= 4'd3 && v <= 4'd9 && $urandom_range(0, 5) == 0)
        begin
            if (v == 4'd3 && $urandom_range(0, 1) == 1)
                return EtxByte;
            return LetterOff + 8'(v);
        end
        if (v < 4'd10)
            return HexLow + 8'(v);
        return LetterOff + 8'(v);
    endfunction

    // anything the receiver refuses inside a frame; a start byte restarts
    function automatic logic [7:0] bad_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0)
            return StxByte;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= HexLow && b <= HexHigh) || b == EtxByte);
        return b;
    endfunction

    // one frame of payload length plen: well formed most of the time, else
    // cut short by an illegal byte or run past its end
    task automatic send_frame(input logic [7:0] plen);
        logic [7:0]  frame_bytes[$];
        int unsigned kind;
        int unsigned cut;
        frame_bytes.push_back(StxByte);
        repeat (6) frame_bytes.push_back(frame_char());
        frame_bytes.push_back(digit_char(plen[7:4]));
        frame_bytes.push_back(digit_char(plen[3:0]));
        repeat (int'(plen) + 2) frame_bytes.push_back(frame_char());
        frame_bytes.push_back(EtxByte);
        kind = $urandom_range(0, 9);
        if (kind >= 6 && kind <= 7)
        begin
            // abort somewhere in the frame, including inside the length field
            cut = $urandom_range(1, frame_bytes.size() - 1);
            frame_bytes[cut] = bad_byte();
            while (frame_bytes.size() > cut + 1)
                void'(frame_bytes.pop_back());
        end
        else if (kind >= 8)
        begin
            // overrun: last byte is not the end marker, then more follow
            frame_bytes[frame_bytes.size() - 1] = 8'($urandom_range(HexLow, HexHigh));
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(frame_char());
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        bytes_sent += frame_bytes.size();
    endtask

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] plen;
        directed = {
            // outside a frame: all ignored
            8'hFF, 8'h00, EtxByte,
            // zero-length frame with an early end marker stored as data
            StxByte, 8'h31, EtxByte, 8'h41, 8'h46, 8'h39, 8'h30,
            8'h30, 8'h30, 8'h45, 8'h42, EtxByte,
            // illegal byte aborts
            StxByte, 8'h41, 8'h7F,
            // start byte inside a frame restarts it, then 'G' aborts
            StxByte, 8'h31, StxByte, 8'h47
        };

        // reset held at start, released once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with no idling
        foreach (directed[i])
            send_byte(directed[i]);

        // random frames, first one at the largest payload length
        plen = 8'hFF;
        while (bytes_sent < RandomBytes)
        begin
            if (bytes_sent >= QuietFrom)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            // noise between frames
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            send_frame(plen);
            // mostly short payloads, a few large ones
            if ($urandom_range(0, 19) == 0)
                plen = 8'($urandom_range(200, 255));
            else
                plen = 8'($urandom_range(0, 24));
        end
        s_tvalid <= 1'b0;

        // let the checker count the last request, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ahlfr_pkg.sv
rtl/ahlfr_in_reg.sv
rtl/ahlfr_core.sv
rtl/ahlfr_out_reg.sv
rtl/ascii_hex_length_frame_receiver.sv
tb/frame_event_checker.sv
tb/tb_ascii_hex_length_frame_receiver.sv
